/* design/csid_pkg.sv */
`default_nettype none

package csid_pkg;

    // default depth of the container stack
    localparam int MAX_NESTING_DEF = 16;

    // width of an items-due count: a map doubles a 16-bit count
    localparam int CNT_W = 17;

    // result kinds
    localparam logic [1:0] KIND_HEAD    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TRUNCATED = 3'd1;
    localparam logic [2:0] ERR_MALFORMED = 3'd2;
    localparam logic [2:0] ERR_COUNT     = 3'd3;
    localparam logic [2:0] ERR_DEPTH     = 3'd4;

    // major types
    localparam logic [2:0] MAJ_BSTR  = 3'd2;
    localparam logic [2:0] MAJ_TSTR  = 3'd3;
    localparam logic [2:0] MAJ_ARRAY = 3'd4;
    localparam logic [2:0] MAJ_MAP   = 3'd5;
    localparam logic [2:0] MAJ_TAG   = 3'd6;

    // additional info codes
    localparam logic [4:0] AI_DIRECT_MAX = 5'd23;
    localparam logic [4:0] AI_ARG8       = 5'd24;
    localparam logic [4:0] AI_ARG16      = 5'd25;
    localparam logic [4:0] AI_ARG32      = 5'd26;
    localparam logic [4:0] AI_BAD_LO     = 5'd27;
    localparam logic [4:0] AI_BAD_HI     = 5'd31;

    // largest string length or container count
    localparam logic [31:0] ARG_LIMIT = 32'h0000_FFFF;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_ARG,
        PH_PAYLOAD
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [2:0]  head_major;
        logic [31:0] argument;
        logic [2:0]  head_length;
        logic [7:0]  payload_byte;
        logic [2:0]  error_code;
        logic        item_complete;
        logic [4:0]  nest_level;
    } t_out_word;

endpackage

`default_nettype wire

/* design/csid_stream_if.sv */
`default_nettype none

interface csid_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/csid_ram.sv */
`default_nettype none

module csid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

/* design/cbor_stream_item_decoder.sv */
// CBOR item head decoder. One byte word is taken per clock, back to back, with no stall of
// its own: i_in.ready drops only when two result words are already waiting on o_out. Each
// byte gives zero or one result word, registered into the two-word output buffer.
// Heads (initial byte plus 0, 1, 2 or 4 big-endian argument bytes) give one head word when
// complete, string bytes are passed out one word each, and malformed input, oversized
// counts, nesting deeper than MAX_NESTING and a buffer ending mid-item give an error; after
// any error decoding restarts at top level. The nesting stack lives in a one-port-write,
// one-port-read RAM of MAX_NESTING entries: the innermost count sits in registers, every
// lower entry stores its count already reduced by the child above it plus the level an end
// lands on, so a cascade of closing containers resolves on the closing byte itself. The entry at the
// landing level is kept prefetched, and refilled by one RAM read after each pop, which keeps
// the one-byte-per-clock rate with no interlock. Stack entries are written on push before
// they are ever read, so the RAM needs no clearing pass after reset.
`default_nettype none

module cbor_stream_item_decoder #(
    parameter int MAX_NESTING = csid_pkg::MAX_NESTING_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    csid_stream_if.sink   i_in,
    csid_stream_if.source o_out
);
    import csid_pkg::*;

    localparam int LVL_W = $clog2(MAX_NESTING + 1);
    localparam int AW    = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
    localparam int ENT_W = CNT_W + LVL_W;

    // byte decode
    t_in_word   in_w;
    logic       in_acc;
    logic [7:0] b;
    logic [2:0] b_major;
    logic [4:0] b_ai;

    // head and string state
    t_phase      r_phase, n_phase;
    logic [2:0]  r_held, n_held;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_abl, n_abl;
    logic [2:0]  r_hbs, n_hbs;
    logic [15:0] r_sbl, n_sbl;

    // stack: depth, innermost count and its landing level, prefetched landing entry
    logic [LVL_W-1:0] r_level, n_level;
    logic [CNT_W-1:0] r_top_cnt, n_top_cnt;
    logic [LVL_W-1:0] r_top_land, n_top_land;
    logic [CNT_W-1:0] r_pf_cnt, n_pf_cnt, pf_cnt_cur;
    logic [LVL_W-1:0] r_pf_land, n_pf_land, pf_land_cur;
    logic             r_pf_pend, n_pf_pend;

    // stack ram
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    logic [ENT_W-1:0] mem_wdata;
    logic [ENT_W-1:0] mem_rdata;
    logic [LVL_W-1:0] wlvl_m1;
    logic [LVL_W-1:0] rlvl_m1;

    // per-byte work
    logic             res_have;
    t_out_word        res;
    logic [2:0]       fail_code;
    logic             do_head;
    logic             do_end;
    logic [2:0]       h_major;
    logic [31:0]      h_arg;
    logic [2:0]       h_len;
    logic [CNT_W-1:0] top_dec;
    logic             is_str;
    logic             is_cont;
    logic [LVL_W+4:0] nest_ext;

    // two-word output buffer
    logic      r_va, r_vb;
    t_out_word r_a, r_b;
    logic      out_pop;
    logic      out_push;

    assign in_w    = i_in.data;
    assign in_acc  = i_in.valid & i_in.ready;
    assign b       = in_w.in_byte;
    assign b_major = b[7:5];
    assign b_ai    = b[4:0];

    assign top_dec = r_top_cnt - 1'b1;

    // landing entry: straight from the ram in the cycle after a pop
    assign pf_cnt_cur  = r_pf_pend ? mem_rdata[ENT_W-1:LVL_W] : r_pf_cnt;
    assign pf_land_cur = r_pf_pend ? mem_rdata[LVL_W-1:0]     : r_pf_land;

    assign wlvl_m1   = r_level - 1'b1;
    assign rlvl_m1   = pf_land_cur - 1'b1;
    assign mem_waddr = wlvl_m1[AW-1:0];
    assign mem_raddr = rlvl_m1[AW-1:0];
    assign mem_wdata = {top_dec, r_top_land};

    csid_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_NESTING)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_phase    = r_phase;
        n_held     = r_held;
        n_acc      = r_acc;
        n_abl      = r_abl;
        n_hbs      = r_hbs;
        n_sbl      = r_sbl;
        n_level    = r_level;
        n_top_cnt  = r_top_cnt;
        n_top_land = r_top_land;
        n_pf_cnt   = pf_cnt_cur;
        n_pf_land  = pf_land_cur;
        n_pf_pend  = 1'b0;
        mem_we     = 1'b0;
        res_have   = 1'b0;
        res        = '0;
        fail_code  = ERR_NONE;
        do_head    = 1'b0;
        do_end     = 1'b0;
        h_major    = b_major;
        h_arg      = {27'd0, b_ai};
        h_len      = 3'd1;
        is_str     = 1'b0;
        is_cont    = 1'b0;
        nest_ext   = '0;

        if (in_acc) begin
            case (r_phase)
                PH_ARG: begin
                    n_acc = {r_acc[23:0], b};
                    n_abl = r_abl - 3'd1;
                    n_hbs = r_hbs + 3'd1;
                    if (r_abl == 3'd1) begin
                        do_head = 1'b1;
                        h_major = r_held;
                        h_arg   = n_acc;
                        h_len   = n_hbs;
                    end
                end
                PH_PAYLOAD: begin
                    res_have         = 1'b1;
                    res.out_kind     = KIND_PAYLOAD;
                    res.head_major   = r_held;
                    res.payload_byte = b;
                    n_sbl            = r_sbl - 16'd1;
                    if (r_sbl == 16'd1) begin
                        n_phase = PH_HEAD;
                        do_end  = 1'b1;
                    end
                end
                default: begin
                    if (b_ai inside {[AI_BAD_LO:AI_BAD_HI]} || b_major == MAJ_TAG) begin
                        fail_code = ERR_MALFORMED;
                    end else if (b_ai <= AI_DIRECT_MAX) begin
                        do_head = 1'b1;
                    end else begin
                        n_held  = b_major;
                        n_acc   = '0;
                        n_hbs   = 3'd1;
                        n_abl   = (b_ai == AI_ARG8) ? 3'd1 : (b_ai == AI_ARG16) ? 3'd2 : 3'd4;
                        n_phase = PH_ARG;
                    end
                end
            endcase

            // complete head: range checks, then string, container or scalar
            if (do_head) begin
                n_phase = PH_HEAD;
                n_abl   = '0;
                n_hbs   = '0;
                is_str  = (h_major == MAJ_BSTR) || (h_major == MAJ_TSTR);
                is_cont = (h_major == MAJ_ARRAY) || (h_major == MAJ_MAP);
                if (is_str && h_arg > ARG_LIMIT) begin
                    fail_code = ERR_TRUNCATED;
                end else if (is_cont && h_arg > ARG_LIMIT) begin
                    fail_code = ERR_COUNT;
                end else if (is_cont && h_arg != 32'd0 &&
                             r_level >= LVL_W'(MAX_NESTING)) begin
                    fail_code = ERR_DEPTH;
                end else begin
                    res_have        = 1'b1;
                    res.out_kind    = KIND_HEAD;
                    res.head_major  = h_major;
                    res.argument    = h_arg;
                    res.head_length = h_len;
                    if (h_arg == 32'd0 || !(is_str || is_cont)) begin
                        do_end = 1'b1;
                    end else if (is_str) begin
                        n_held  = h_major;
                        n_sbl   = h_arg[15:0];
                        n_phase = PH_PAYLOAD;
                    end else begin
                        // push: the old top goes to ram, pre-reduced by this child
                        n_level   = r_level + 1'b1;
                        n_top_cnt = (h_major == MAJ_MAP) ? {h_arg[15:0], 1'b0}
                                                         : {1'b0, h_arg[15:0]};
                        if (r_level == '0) begin
                            n_top_land = '0;
                        end else begin
                            mem_we = 1'b1;
                            if (top_dec != '0) begin
                                n_top_land = r_level;
                                n_pf_cnt   = top_dec;
                                n_pf_land  = r_top_land;
                            end else begin
                                n_top_land = r_top_land;
                            end
                        end
                    end
                end
            end

            // an item ended: count down, closing every container that runs out
            if (do_end) begin
                if (r_level == '0) begin
                    res.item_complete = 1'b1;
                end else if (top_dec != '0) begin
                    n_top_cnt = top_dec;
                end else begin
                    n_level = r_top_land;
                    if (r_top_land == '0) begin
                        res.item_complete = 1'b1;
                    end else begin
                        n_top_cnt  = pf_cnt_cur;
                        n_top_land = pf_land_cur;
                        n_pf_pend  = (pf_land_cur != '0);
                    end
                end
            end

            if (fail_code != ERR_NONE) begin
                res_have       = 1'b1;
                res            = '0;
                res.out_kind   = KIND_ERROR;
                res.error_code = fail_code;
                n_phase        = PH_HEAD;
                n_level        = '0;
                n_abl          = '0;
                n_hbs          = '0;
                n_sbl          = '0;
            end else if (in_w.last_byte && (n_phase != PH_HEAD || n_level != '0)) begin
                // buffer ends mid-item
                if (res_have) begin
                    res.error_code    = ERR_TRUNCATED;
                    res.item_complete = 1'b0;
                end else begin
                    res_have       = 1'b1;
                    res            = '0;
                    res.out_kind   = KIND_ERROR;
                    res.error_code = ERR_TRUNCATED;
                end
                n_phase = PH_HEAD;
                n_level = '0;
                n_abl   = '0;
                n_hbs   = '0;
                n_sbl   = '0;
            end

            nest_ext       = {5'd0, n_level};
            res.nest_level = nest_ext[4:0];
        end
    end

    // output buffer: head word plus one skid word
    assign out_pop  = r_va & o_out.ready;
    assign out_push = in_acc & res_have;

    assign i_in.ready  = ~r_vb;
    assign o_out.valid = r_va;
    assign o_out.data  = r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEAD;
            r_level   <= '0;
            r_pf_pend <= 1'b0;
            r_va      <= 1'b0;
            r_vb      <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_level   <= n_level;
            r_pf_pend <= n_pf_pend;
            if (r_vb) begin
                if (out_pop) begin
                    r_vb <= 1'b0;
                end
            end else if (out_push) begin
                if (r_va && !out_pop) begin
                    r_vb <= 1'b1;
                end else begin
                    r_va <= 1'b1;
                end
            end else if (out_pop) begin
                r_va <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_held     <= n_held;
        r_acc      <= n_acc;
        r_abl      <= n_abl;
        r_hbs      <= n_hbs;
        r_sbl      <= n_sbl;
        r_top_cnt  <= n_top_cnt;
        r_top_land <= n_top_land;
        r_pf_cnt   <= n_pf_cnt;
        r_pf_land  <= n_pf_land;
        if (r_vb) begin
            if (out_pop) begin
                r_a <= r_b;
            end
        end else if (out_push) begin
            if (r_va && !out_pop) begin
                r_b <= res;
            end else begin
                r_a <= res;
            end
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vb |-> r_va)
        else $error("skid word held without head word");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_W'(MAX_NESTING))
        else $error("nesting level beyond stack depth");

    a_land_below_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level != '0) |-> (r_top_land < r_level))
        else $error("landing level not below top");

    a_error_to_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && res_have && res.error_code != ERR_NONE) |=>
            (r_level == '0 && r_phase == PH_HEAD))
        else $error("decoder not back at top level after error");
`endif
endmodule

`default_nettype wire
